FILE: rtl/matrix_key_debounce_autorepeat_assert.svh
// Assertion macros shared by the keypad debounce RTL.
`ifndef MATRIX_KEY_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define MATRIX_KEY_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

// Checked only while out of reset.
`define MKDA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MKDA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/mkda_pkg.sv
// Types, constants and the key remap table of the keypad debounce block.
package mkda_pkg;

    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLS    = 4;
    localparam int KEY_COUNT   = 16;
    localparam int KEY_W       = $clog2(KEY_COUNT);
    localparam int TICK_W      = 8;
    localparam int LIN_W       = 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TICK_W-1:0] FIRST_DELAY_RST     = 8'd30;
    localparam logic [TICK_W-1:0] REPEAT_INTERVAL_RST = 8'd20;
    localparam logic [TICK_W-1:0] RELEASE_HOLDOFF_RST = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HOLDOFF = 2'd2;

    localparam logic [KEY_W-1:0] REMAP_TAB [KEY_COUNT] = '{
        4'd13, 4'd12, 4'd11, 4'd10,
        4'd15, 4'd9,  4'd6,  4'd3,
        4'd0,  4'd8,  4'd5,  4'd2,
        4'd14, 4'd7,  4'd4,  4'd1
    };

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CONFIRM = 3'd1,
        PH_FIRST   = 3'd2,
        PH_REPEAT  = 3'd3,
        PH_HOLD    = 3'd4
    } t_phase;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] column;
        logic       pressed;
    } t_in;

    typedef struct packed {
        logic [KEY_W-1:0] key_code;
        logic             is_on;
    } t_out;

    typedef struct packed {
        logic [TICK_W-1:0] first_delay;
        logic [TICK_W-1:0] repeat_interval;
        logic [TICK_W-1:0] release_holdoff;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic [TICK_W-1:0] ticks;
    } t_key_state;

    typedef struct packed {
        logic emit;
        logic is_on;
    } t_event;

endpackage

FILE: rtl/mkda_key_update.sv
// Per-key phase machine: next phase, next tick count and the event of one sample.
module mkda_key_update (
    input  mkda_pkg::t_key_state          i_state,
    input  logic                          i_pressed,
    input  mkda_pkg::t_cfg                i_cfg,
    output mkda_pkg::t_key_state          o_next,
    output mkda_pkg::t_event              o_event
);
    import mkda_pkg::*;

    logic [TICK_W-1:0] ticks_inc;

    assign ticks_inc = i_state.ticks + 8'd1;

    // Next state.
    always_comb begin
        o_next = i_state;
        unique case (i_state.phase)
            PH_IDLE: begin
                if (i_pressed) begin
                    o_next.phase = PH_CONFIRM;
                end
            end
            PH_CONFIRM: begin
                if (i_pressed) begin
                    o_next.phase = PH_FIRST;
                    o_next.ticks = '0;
                end else begin
                    o_next.phase = PH_IDLE;
                end
            end
            PH_FIRST: begin
                if (i_pressed) begin
                    if (i_state.ticks >= i_cfg.first_delay) begin
                        o_next.phase = PH_REPEAT;
                        o_next.ticks = '0;
                    end else begin
                        o_next.ticks = ticks_inc;
                    end
                end else begin
                    o_next.phase = PH_HOLD;
                    o_next.ticks = '0;
                end
            end
            PH_REPEAT: begin
                if (i_pressed) begin
                    if (i_state.ticks >= i_cfg.repeat_interval) begin
                        o_next.ticks = '0;
                    end else begin
                        o_next.ticks = ticks_inc;
                    end
                end else begin
                    o_next.phase = PH_HOLD;
                    o_next.ticks = '0;
                end
            end
            PH_HOLD: begin
                // The contact is not looked at until the holdoff has run out.
                if (i_state.ticks < i_cfg.release_holdoff) begin
                    o_next.ticks = ticks_inc;
                end else begin
                    o_next.phase = PH_IDLE;
                end
            end
            default: begin
                o_next.phase = PH_IDLE;
            end
        endcase
    end

    // Event output.
    always_comb begin
        o_event = '0;
        unique case (i_state.phase)
            PH_CONFIRM: begin
                o_event.emit  = 1'b1;
                o_event.is_on = i_pressed;
            end
            PH_FIRST: begin
                o_event.emit  = !i_pressed || (i_state.ticks >= i_cfg.first_delay);
                o_event.is_on = i_pressed;
            end
            PH_REPEAT: begin
                o_event.emit  = !i_pressed || (i_state.ticks >= i_cfg.repeat_interval);
                o_event.is_on = i_pressed;
            end
            default: begin
                o_event = '0;
            end
        endcase
    end

endmodule

FILE: rtl/matrix_key_debounce_autorepeat.sv
// Top level of the keypad debounce and auto-repeat block.
// One keypad sample request is taken every clock while the output is not held
// up. A sample is registered at acceptance, its key's phase and tick count are
// read, updated and written back when it leaves the update stage, and any ON or
// OFF event lands in the output register at that same edge. The rate of one
// sample per clock is set by that single read-modify-write of the per-key
// state, which lives in flip-flops and is cleared by reset. While a result
// waits at the output without being taken, the sample in the update stage is
// held and no further request is accepted; if that stage is empty, one request
// is still taken into it.
module matrix_key_debounce_autorepeat (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mkda_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mkda_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  logic [mkda_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mkda_pkg::TICK_W-1:0]   i_cfg_data
);
    import mkda_pkg::*;

    t_cfg              r_cfg;
    logic              r_s1_valid;
    logic              r_s1_in_grid;
    logic [KEY_W-1:0]  r_s1_key;
    logic              r_s1_pressed;
    t_phase            r_phase [KEY_COUNT];
    logic [TICK_W-1:0] r_ticks [KEY_COUNT];
    logic              r_out_valid;
    t_out              r_out;

    logic              n_in_grid;
    logic [LIN_W-1:0]  n_lin;
    logic [KEY_W-1:0]  n_key;
    logic              in_fire;
    logic              advance;
    t_key_state        cur_state;
    t_key_state        upd_state;
    t_event            upd_event;

    // Position to key code.
    always_comb begin
        n_in_grid = (int'(i_in_data.row) < NUM_ROWS) && (int'(i_in_data.column) < NUM_COLS);
        n_lin     = LIN_W'(int'(i_in_data.row) * NUM_COLS + int'(i_in_data.column));
        n_key     = (n_lin < LIN_W'(KEY_COUNT)) ? REMAP_TAB[n_lin[KEY_W-1:0]]
                                                : n_lin[KEY_W-1:0];
    end

    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_delay     <= FIRST_DELAY_RST;
            r_cfg.repeat_interval <= REPEAT_INTERVAL_RST;
            r_cfg.release_holdoff <= RELEASE_HOLDOFF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_DELAY:     r_cfg.first_delay     <= i_cfg_data;
                CFG_REPEAT_INTERVAL: r_cfg.repeat_interval <= i_cfg_data;
                CFG_RELEASE_HOLDOFF: r_cfg.release_holdoff <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_in_grid <= n_in_grid;
            r_s1_key     <= n_key;
            r_s1_pressed <= i_in_data.pressed;
        end
    end

    assign cur_state.phase = r_phase[r_s1_key];
    assign cur_state.ticks = r_ticks[r_s1_key];

    mkda_key_update u_key_update (
        .i_state   (cur_state),
        .i_pressed (r_s1_pressed),
        .i_cfg     (r_cfg),
        .o_next    (upd_state),
        .o_event   (upd_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_phase[k] <= PH_IDLE;
                r_ticks[k] <= '0;
            end
        end else if (advance && r_s1_in_grid) begin
            r_phase[r_s1_key] <= upd_state.phase;
            r_ticks[r_s1_key] <= upd_state.ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_in_grid && upd_event.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_in_grid && upd_event.emit) begin
            r_out.key_code <= r_s1_key;
            r_out.is_on    <= upd_event.is_on;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "matrix_key_debounce_autorepeat_assert.svh"

    `MKDA_ASSERT(a_no_result_after_reset, !$past(i_rst_n) |-> !o_out_valid, "result offered straight after reset")
    `MKDA_ASSERT(a_event_key, advance && r_s1_in_grid && upd_event.emit |=> o_out_valid && o_out_data.key_code == $past(r_s1_key), "event lost or wrong key")
    `MKDA_ASSERT(a_off_grid_silent, advance && !r_s1_in_grid |=> !o_out_valid, "off-grid sample gave a result")
    `MKDA_ASSERT(a_stall_cause, r_s1_valid && !advance |-> o_out_valid && !i_out_ready, "update stage stalled without a waiting result")

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the keypad debounce and auto-repeat block.
`timescale 1ns / 1ps

module testbench;
    import mkda_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Key code for each linear position, row major.
    localparam logic [3:0] KEY_AT [16] = '{
        4'd13, 4'd12, 4'd11, 4'd10,
        4'd15, 4'd9,  4'd6,  4'd3,
        4'd0,  4'd8,  4'd5,  4'd2,
        4'd14, 4'd7,  4'd4,  4'd1
    };

    typedef struct {
        t_in sample;
        int  gap;
        bit  drain;
    } sample_req_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_data = '0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0] cfg_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // Mirror of the per-key state and of the registers.
    t_phase            key_phase_m [16];
    logic [TICK_W-1:0] key_ticks_m [16];
    logic [TICK_W-1:0] cfg_first = FIRST_DELAY_RST;
    logic [TICK_W-1:0] cfg_repeat = REPEAT_INTERVAL_RST;
    logic [TICK_W-1:0] cfg_holdoff = RELEASE_HOLDOFF_RST;

    sample_req_t pending_samples [$];
    t_out        awaited_events [$];

    int  issued_count = 0;
    int  accepted_count = 0;
    int  gap_left = 0;
    bit  gap_armed = 1'b0;
    int  stall_left = 0;
    int  stretch_left = 0;
    bit  stall_quiet = 1'b0;
    bit  sender_quiet = 1'b0;
    bit  long_done = 1'b0;
    int  phase_items = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;

    matrix_key_debounce_autorepeat u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Advances the key touched by one sample and queues the event it raises.
    function automatic void track_key_sample(t_in s);
        int                lin;
        logic [3:0]        key;
        logic [TICK_W-1:0] old;
        bit                emit;
        bit                on;
        emit = 1'b0;
        on = 1'b0;
        if (s.row >= NUM_ROWS || s.column >= NUM_COLS) begin
            return;
        end
        lin = s.row * NUM_COLS + s.column;
        key = (lin < 16) ? KEY_AT[lin] : lin[3:0];
        case (key_phase_m[key]) inside
            PH_IDLE: begin
                if (s.pressed) begin
                    key_phase_m[key] = PH_CONFIRM;
                end
            end
            PH_CONFIRM: begin
                emit = 1'b1;
                if (s.pressed) begin
                    key_phase_m[key] = PH_FIRST;
                    key_ticks_m[key] = '0;
                    on = 1'b1;
                end else begin
                    key_phase_m[key] = PH_IDLE;
                end
            end
            PH_FIRST, PH_REPEAT: begin
                if (s.pressed) begin
                    old = key_ticks_m[key];
                    key_ticks_m[key] = old + 1'b1;
                    if (old >= ((key_phase_m[key] == PH_FIRST) ? cfg_first : cfg_repeat)) begin
                        key_phase_m[key] = PH_REPEAT;
                        key_ticks_m[key] = '0;
                        emit = 1'b1;
                        on = 1'b1;
                    end
                end else begin
                    key_ticks_m[key] = '0;
                    key_phase_m[key] = PH_HOLD;
                    emit = 1'b1;
                end
            end
            PH_HOLD: begin
                if (key_ticks_m[key] < cfg_holdoff) begin
                    key_ticks_m[key] = key_ticks_m[key] + 1'b1;
                end else begin
                    key_phase_m[key] = PH_IDLE;
                end
            end
            default: begin
                key_phase_m[key] = PH_IDLE;
            end
        endcase
        if (emit) begin
            awaited_events.push_back('{key_code: key, is_on: on});
        end
    endfunction

    // Sender: one request at a time, with a drawn gap before each.
    always @(posedge i_clk) begin
        bit          next_valid;
        sample_req_t head;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            if (in_valid && o_in_ready) begin
                track_key_sample(in_data);
                accepted_count++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_samples.size() != 0) begin
                head = pending_samples[0];
                if (!gap_armed) begin
                    gap_left = head.gap;
                    gap_armed = 1'b1;
                end
                if (head.drain && awaited_events.size() != 0) begin
                    // Hold back until every outstanding event has been taken.
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    void'(pending_samples.pop_front());
                    in_data <= head.sample;
                    next_valid = 1'b1;
                    gap_armed = 1'b0;
                    issued_count++;
                end
            end
            in_valid <= next_valid;
        end
    end

    // Receiver: checks each event and stalls for a drawn number of cycles after it.
    always @(posedge i_clk) begin
        t_out want;
        int   n;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (!out_ready) begin
            if (stall_left == 0) begin
                out_ready <= 1'b1;
            end else begin
                stall_left--;
            end
        end else if (o_out_valid) begin
            if (awaited_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected event: key %0d is_on %0b",
                             o_out_data.key_code, o_out_data.is_on);
                end
            end else begin
                want = awaited_events.pop_front();
                if (o_out_data.key_code !== want.key_code || o_out_data.is_on !== want.is_on) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("event mismatch: expected key %0d is_on %0b, got key %0d is_on %0b",
                                 want.key_code, want.is_on, o_out_data.key_code, o_out_data.is_on);
                    end
                end
            end
            if (stretch_left == 0) begin
                stall_quiet = ($urandom_range(0, 2) == 0);
                stretch_left = $urandom_range(10, 40);
            end else begin
                stretch_left--;
            end
            n = stall_quiet ? 0 : $urandom_range(0, 15);
            if (n > 0) begin
                out_ready <= 1'b0;
                stall_left = n - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_sample(logic [1:0] r, logic [1:0] c, logic p, bit drain);
        sample_req_t req;
        req.sample = '{row: r, column: c, pressed: p};
        req.gap = sender_quiet ? 0 : $urandom_range(0, 15);
        req.drain = drain;
        pending_samples.push_back(req);
        phase_items++;
    endtask

    // Waits until every request is taken and every event has come out.
    task automatic wait_until_quiet();
        do begin
            @(posedge i_clk);
        end while (pending_samples.size() != 0 || issued_count != accepted_count
                   || awaited_events.size() != 0);
        // Samples that raise no event may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_FIRST_DELAY:     cfg_first = val;
            CFG_REPEAT_INTERVAL: cfg_repeat = val;
            CFG_RELEASE_HOLDOFF: cfg_holdoff = val;
            default: ;
        endcase
    endtask

    task automatic configure(int first, int rep, int hold);
        wait_until_quiet();
        write_register(CFG_FIRST_DELAY, TICK_W'(first));
        write_register(CFG_REPEAT_INTERVAL, TICK_W'(rep));
        write_register(CFG_RELEASE_HOLDOFF, TICK_W'(hold));
        // An index past the last register must leave everything alone.
        if ($urandom_range(0, 1) == 0) begin
            write_register(CFG_UNUSED, TICK_W'($urandom_range(0, 255)));
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        phase_items = 0;
        long_done = 1'b0;
    endtask

    // One keystroke on a random key, with stray samples mixed in, a bounce that fails confirmation, or plain noise.
    task automatic add_burst();
        logic [1:0] r;
        logic [1:0] c;
        int         kind;
        int         n_press;
        int         n_rel;
        int         cap;
        bit         drain;
        r = 2'($urandom_range(0, 3));
        c = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
            sender_quiet = !sender_quiet;
        end
        drain = ($urandom_range(0, 19) == 0);
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            repeat ($urandom_range(1, 6)) begin
                add_sample(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), drain);
                drain = 1'b0;
            end
        end else if (kind == 2) begin
            // A bounce that fails confirmation, sometimes twice.
            repeat ($urandom_range(1, 2)) begin
                add_sample(r, c, 1'b1, drain);
                add_sample(r, c, 1'b0, 1'b0);
                drain = 1'b0;
            end
        end else begin
            cap = cfg_first + 3 * (cfg_repeat + 1) + 2;
            if (cfg_first > 40 && !long_done) begin
                n_press = cfg_first + 2 + $urandom_range(0, 8);
                long_done = 1'b1;
            end else begin
                n_press = $urandom_range(1, (cap > 40) ? 40 : cap);
            end
            for (int i = 0; i < n_press; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    add_sample(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), 1'b0);
                end
                add_sample(r, c, 1'b1, drain);
                drain = 1'b0;
            end
            add_sample(r, c, 1'b0, 1'b0);
            n_rel = (cfg_holdoff < 40) ? cfg_holdoff + 1 + $urandom_range(0, 2)
                                       : $urandom_range(1, 20);
            repeat (n_rel) add_sample(r, c, 1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    task automatic run_phase(int first, int rep, int hold, int budget, bit force_drain);
        configure(first, rep, hold);
        while (phase_items < budget) begin
            add_burst();
            if (force_drain && phase_items > budget / 2) begin
                add_sample(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b1, 1'b1);
                force_drain = 1'b0;
            end
        end
    endtask

    // Short scripted walk through every phase with extreme positions.
    t_in directed_samples [22] = '{
        5'b00_00_0, 5'b00_00_1, 5'b00_00_0, 5'b11_11_1, 5'b11_11_1, 5'b11_11_1,
        5'b11_11_1, 5'b11_11_1, 5'b11_11_0, 5'b11_11_1, 5'b11_11_1, 5'b11_11_1,
        5'b11_11_1, 5'b00_11_1, 5'b00_11_1, 5'b00_11_0, 5'b00_11_0, 5'b00_11_0,
        5'b11_00_1, 5'b11_00_0, 5'b11_11_0, 5'b01_10_1
    };

    initial begin
        for (int k = 0; k < 16; k++) begin
            key_phase_m[k] = PH_IDLE;
            key_ticks_m[k] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(1, 0, 1);
        foreach (directed_samples[k]) begin
            add_sample(directed_samples[k].row, directed_samples[k].column,
                       directed_samples[k].pressed, 1'b0);
        end

        run_phase(int'(FIRST_DELAY_RST), int'(REPEAT_INTERVAL_RST), int'(RELEASE_HOLDOFF_RST),
                  110, 1'b1);
        run_phase(0, 0, 0, 110, 1'b0);
        run_phase(255, 255, 255, 290, 1'b0);
        run_phase($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6), 80, 1'b1);
        run_phase($urandom_range(0, 12), $urandom_range(0, 4), $urandom_range(0, 20), 80,
                  1'b0);

        wait_until_quiet();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
